// ----- hw/rtl/slnw_pkg.sv -----
// Shared types, constants and control-store program of the serial LCD number writer.
package slnw_pkg;

    localparam int PRINT_DIGITS = 7;
    localparam int BLANK_CELLS  = 9;

    localparam int CONV_BITS  = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CONV_CNT_W = $clog2(CONV_BITS);
    localparam int DIG_W      = $clog2(BCD_DIGITS);
    localparam int REP_W      = $clog2(BLANK_CELLS + 1);
    localparam int PC_W       = 5;
    localparam int SETTLE_W   = 10;

    localparam logic [2:0] REQ_CMD  = 3'd0;
    localparam logic [2:0] REQ_DATA = 3'd1;
    localparam logic [2:0] REQ_BYTE = 3'd2;
    localparam logic [2:0] REQ_INT  = 3'd3;
    localparam logic [2:0] REQ_TEMP = 3'd4;

    localparam logic [7:0] SYNC_CMD  = 8'hF8;
    localparam logic [7:0] SYNC_DATA = 8'hFA;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_CEL   = 8'h43;

    localparam logic [PC_W-1:0] PC_CMD        = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DATA       = PC_W'(1);
    localparam logic [PC_W-1:0] PC_BYTE       = PC_W'(2);
    localparam logic [PC_W-1:0] PC_TEMP       = PC_W'(7);
    localparam logic [PC_W-1:0] PC_INT        = PC_W'(14);
    localparam logic [PC_W-1:0] PC_INT_DIGITS = PC_W'(21);
    localparam logic [PC_W-1:0] PC_INT_ZERO   = PC_W'(22);

    typedef enum logic [2:0] {
        OP_CONV,
        OP_EMIT,
        OP_BRANCH,
        OP_DIGITS,
        OP_HALT
    } op_t;

    typedef enum logic [3:0] {
        SRC_RAW,
        SRC_ADDR,
        SRC_SPACE,
        SRC_ZERO,
        SRC_MINUS,
        SRC_HUND,
        SRC_TENS,
        SRC_UNITS,
        SRC_DOT,
        SRC_CEL
    } src_t;

    typedef enum logic [2:0] {
        LAST_NO,
        LAST_YES,
        LAST_REP,
        LAST_ADDR2,
        LAST_MINUS
    } last_t;

    typedef enum logic {
        COND_ZERO,
        COND_POS
    } cond_t;

    typedef struct packed {
        op_t              op;
        src_t             src;
        logic             is_data;
        last_t            last;
        logic [REP_W-1:0] count;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic                 start;
        logic [CONV_BITS-1:0] operand;
    } conv_req_t;

    typedef struct packed {
        logic busy;
    } conv_stat_t;

    localparam last_t ZERO_LAST = (BLANK_CELLS == 1) ? LAST_YES : LAST_NO;

    function automatic ctrl_t uword(op_t op, src_t src, logic is_data, last_t last,
                                    int count, cond_t cond, logic [PC_W-1:0] target);
        ctrl_t w;
        w.op      = op;
        w.src     = src;
        w.is_data = is_data;
        w.last    = last;
        w.count   = REP_W'(count);
        w.cond    = cond;
        w.target  = target;
        return w;
    endfunction

    function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            // raw writes
            5'd0:  w = uword(OP_EMIT, SRC_RAW, 1'b0, LAST_YES, 1, COND_ZERO, PC_CMD);
            5'd1:  w = uword(OP_EMIT, SRC_RAW, 1'b1, LAST_YES, 1, COND_ZERO, PC_CMD);
            // three-digit print
            5'd2:  w = uword(OP_CONV, SRC_RAW, 1'b0, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd3:  w = uword(OP_EMIT, SRC_ADDR, 1'b0, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd4:  w = uword(OP_EMIT, SRC_HUND, 1'b1, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd5:  w = uword(OP_EMIT, SRC_TENS, 1'b1, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd6:  w = uword(OP_EMIT, SRC_UNITS, 1'b1, LAST_YES, 1, COND_ZERO, PC_CMD);
            // temperature print
            5'd7:  w = uword(OP_CONV, SRC_RAW, 1'b0, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd8:  w = uword(OP_EMIT, SRC_ADDR, 1'b0, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd9:  w = uword(OP_EMIT, SRC_HUND, 1'b1, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd10: w = uword(OP_EMIT, SRC_TENS, 1'b1, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd11: w = uword(OP_EMIT, SRC_DOT, 1'b1, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd12: w = uword(OP_EMIT, SRC_UNITS, 1'b1, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd13: w = uword(OP_EMIT, SRC_CEL, 1'b1, LAST_YES, 1, COND_ZERO, PC_CMD);
            // signed integer print
            5'd14: w = uword(OP_CONV, SRC_RAW, 1'b0, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd15: w = uword(OP_EMIT, SRC_ADDR, 1'b0, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd16: w = uword(OP_EMIT, SRC_SPACE, 1'b1, LAST_NO, BLANK_CELLS, COND_ZERO,
                             PC_CMD);
            5'd17: w = uword(OP_EMIT, SRC_ADDR, 1'b0, LAST_ADDR2, 1, COND_ZERO, PC_CMD);
            5'd18: w = uword(OP_BRANCH, SRC_RAW, 1'b0, LAST_NO, 1, COND_ZERO, PC_INT_ZERO);
            5'd19: w = uword(OP_BRANCH, SRC_RAW, 1'b0, LAST_NO, 1, COND_POS,
                             PC_INT_DIGITS);
            5'd20: w = uword(OP_EMIT, SRC_MINUS, 1'b1, LAST_MINUS, 1, COND_ZERO, PC_CMD);
            5'd21: w = uword(OP_DIGITS, SRC_RAW, 1'b1, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd22: w = uword(OP_EMIT, SRC_ADDR, 1'b0, LAST_NO, 1, COND_ZERO, PC_CMD);
            5'd23: w = uword(OP_EMIT, SRC_ZERO, 1'b1, ZERO_LAST, 1, COND_ZERO, PC_CMD);
            5'd24: w = uword(OP_EMIT, SRC_SPACE, 1'b1, LAST_REP, BLANK_CELLS - 1,
                             COND_ZERO, PC_CMD);
            default: w = uword(OP_HALT, SRC_RAW, 1'b0, LAST_NO, 1, COND_ZERO, PC_CMD);
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/slnw_bcd_conv.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module slnw_bcd_conv
    import slnw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  conv_req_t         conv_req,
    output conv_stat_t        conv_stat,
    output logic [BCD_W-1:0]  bcd
);

    logic                  busy_reg;
    logic [CONV_CNT_W-1:0] cnt_reg;
    logic [CONV_BITS-1:0]  bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_adj;

    always_comb begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (conv_req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CONV_CNT_W'(CONV_BITS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (conv_req.start) begin
            bin_reg <= conv_req.operand;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[CONV_BITS-1]};
            bin_reg <= {bin_reg[CONV_BITS-2:0], 1'b0};
        end
    end

    assign conv_stat.busy = busy_reg;
    assign bcd            = bcd_reg;

endmodule

// ----- hw/rtl/serial_lcd_number_writer.sv -----
// Top level: control-store sequencer that turns LCD requests into serial write frames.
// Raw writes: the frame is registered once the output register is free; then the next request is taken.
// Prints: the value is first converted to BCD by the bit-serial converter, then the frames follow,
// one per cycle while m_tready is high; branch steps and skipped leading zeros emit no frame.
// Requests do not overlap: s_tready stays low until the current request has emitted its last frame.
// aresetn is synchronous; it clears the sequencer and output valid and loads the settle registers.
module serial_lcd_number_writer
    import slnw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row_index[1:0], column[5:2], value[37:6], zero[39:38]
    input  logic [2:0]  s_tuser,   // req_type[2:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // frame[23:0], payload[31:24], settle_us[41:32], zero[47:42]
    output logic        m_tuser,   // is_data[0]
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SETTLE_W-1:0] cmd_settle_reg;
    logic [SETTLE_W-1:0] data_settle_reg;

    logic                run_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [REP_W-1:0]    rep_reg;
    logic                wait_reg;
    logic [DIG_W-1:0]    dig_reg;
    logic                started_reg;

    logic [2:0]          type_reg;
    logic [1:0]          row_reg;
    logic [3:0]          col_reg;
    logic [31:0]         value_reg;

    logic                m_tvalid_reg;
    logic [23:0]         frame_reg;
    logic [7:0]          payload_reg;
    logic                is_data_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic                last_reg;

    ctrl_t               ctrl;
    conv_req_t           conv_req;
    conv_stat_t          conv_stat;
    logic [BCD_W-1:0]    bcd;
    logic [3:0]          digit_arr [BCD_DIGITS];
    logic [3:0]          cur_digit;

    logic                out_free;
    logic                in_fire;
    logic                value_zero;
    logic                value_neg;
    logic                digits_zero;
    logic [31:0]         magnitude;
    logic [7:0]          line_base;
    logic [9:0]          hundreds;
    logic                digit_skip;
    logic                emit_fire;
    logic                emit_last;
    logic                emit_is_data;
    logic [7:0]          emit_byte;
    logic                rep_end;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_settle_reg  <= SETTLE_W'(10);
            data_settle_reg <= SETTLE_W'(50);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                data_settle_reg <= pwdata[SETTLE_W-1:0];
            end else begin
                cmd_settle_reg <= pwdata[SETTLE_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? {{(32-SETTLE_W){1'b0}}, data_settle_reg}
                             : {{(32-SETTLE_W){1'b0}}, cmd_settle_reg};

    // datapath
    assign ctrl        = ucode(pc_reg);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign s_tready    = !run_reg;
    assign in_fire     = s_tvalid && s_tready;
    assign value_zero  = (value_reg == 32'd0);
    assign value_neg   = value_reg[31];
    assign magnitude   = value_neg ? (~value_reg + 32'd1) : value_reg;
    assign digits_zero = (bcd[4*PRINT_DIGITS-1:0] == '0);

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            digit_arr[i] = bcd[4*i +: 4];
        end
    end

    assign cur_digit = digit_arr[dig_reg];

    always_comb begin
        unique case (row_reg)
            2'd0: line_base = 8'h80;
            2'd1: line_base = 8'h90;
            2'd2: line_base = 8'h88;
            2'd3: line_base = 8'h98;
            default: line_base = 8'h80;
        endcase
    end

    assign hundreds = 10'(digit_arr[4]) * 10'd100 + 10'(digit_arr[3]) * 10'd10
                    + 10'(digit_arr[2]);

    always_comb begin
        conv_req.start = run_reg && (ctrl.op == OP_CONV) && !wait_reg;
        priority case (type_reg)
            REQ_BYTE: conv_req.operand = {24'd0, value_reg[7:0]};
            REQ_TEMP: conv_req.operand = {16'd0, value_reg[15:0]};
            default:  conv_req.operand = magnitude;
        endcase
    end

    slnw_bcd_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .conv_req  (conv_req),
        .conv_stat (conv_stat),
        .bcd       (bcd)
    );

    assign digit_skip = (cur_digit == 4'd0) && !started_reg;
    assign rep_end    = (rep_reg == ctrl.count - REP_W'(1));

    always_comb begin
        unique case (ctrl.src)
            SRC_RAW:   emit_byte = value_reg[7:0];
            SRC_ADDR:  emit_byte = line_base + {4'd0, col_reg};
            SRC_SPACE: emit_byte = CHR_SPACE;
            SRC_ZERO:  emit_byte = CHR_ZERO;
            SRC_MINUS: emit_byte = CHR_MINUS;
            SRC_HUND:  emit_byte = 8'(hundreds + 10'(CHR_ZERO));
            SRC_TENS:  emit_byte = {4'd0, digit_arr[1]} + CHR_ZERO;
            SRC_UNITS: emit_byte = {4'd0, digit_arr[0]} + CHR_ZERO;
            SRC_DOT:   emit_byte = CHR_DOT;
            SRC_CEL:   emit_byte = CHR_CEL;
            default:   emit_byte = value_reg[7:0];
        endcase
        if (ctrl.op == OP_DIGITS) begin
            emit_byte = {4'd0, cur_digit} + CHR_ZERO;
        end
    end

    always_comb begin
        unique case (ctrl.last)
            LAST_NO:    emit_last = 1'b0;
            LAST_YES:   emit_last = 1'b1;
            LAST_REP:   emit_last = rep_end;
            LAST_ADDR2: emit_last = !value_zero && !value_neg && digits_zero;
            LAST_MINUS: emit_last = digits_zero;
            default:    emit_last = 1'b0;
        endcase
        if (ctrl.op == OP_DIGITS) begin
            emit_last = (dig_reg == '0);
        end
    end

    assign emit_is_data = ctrl.is_data;
    assign emit_fire    = run_reg && out_free
                       && (((ctrl.op == OP_EMIT) && (ctrl.count != '0))
                        || ((ctrl.op == OP_DIGITS) && !digit_skip));

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            pc_reg      <= PC_CMD;
            rep_reg     <= '0;
            wait_reg    <= 1'b0;
            dig_reg     <= '0;
            started_reg <= 1'b0;
        end else if (in_fire) begin
            rep_reg     <= '0;
            wait_reg    <= 1'b0;
            dig_reg     <= DIG_W'(PRINT_DIGITS - 1);
            started_reg <= 1'b0;
            priority case (s_tuser)
                REQ_CMD:  begin run_reg <= 1'b1; pc_reg <= PC_CMD;  end
                REQ_DATA: begin run_reg <= 1'b1; pc_reg <= PC_DATA; end
                REQ_BYTE: begin run_reg <= 1'b1; pc_reg <= PC_BYTE; end
                REQ_INT:  begin run_reg <= 1'b1; pc_reg <= PC_INT;  end
                REQ_TEMP: begin run_reg <= 1'b1; pc_reg <= PC_TEMP; end
                default:  run_reg <= 1'b0;
            endcase
        end else if (run_reg) begin
            unique case (ctrl.op)
                OP_CONV: begin
                    if (!wait_reg) begin
                        wait_reg <= 1'b1;
                    end else if (!conv_stat.busy) begin
                        wait_reg <= 1'b0;
                        pc_reg   <= pc_reg + 1'b1;
                    end
                end
                OP_EMIT: begin
                    if (ctrl.count == '0) begin
                        pc_reg <= pc_reg + 1'b1;
                    end else if (out_free) begin
                        if (emit_last) begin
                            run_reg <= 1'b0;
                        end
                        if (rep_end) begin
                            rep_reg <= '0;
                            pc_reg  <= pc_reg + 1'b1;
                        end else begin
                            rep_reg <= rep_reg + 1'b1;
                        end
                    end
                end
                OP_BRANCH: begin
                    if ((ctrl.cond == COND_ZERO) ? value_zero : !value_neg) begin
                        pc_reg <= ctrl.target;
                    end else begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                end
                OP_DIGITS: begin
                    if (digit_skip) begin
                        dig_reg <= dig_reg - 1'b1;
                        if (dig_reg == '0) begin
                            run_reg <= 1'b0;
                        end
                    end else if (out_free) begin
                        started_reg <= 1'b1;
                        dig_reg     <= dig_reg - 1'b1;
                        if (dig_reg == '0) begin
                            run_reg <= 1'b0;
                        end
                    end
                end
                OP_HALT: run_reg <= 1'b0;
                default: run_reg <= 1'b0;
            endcase
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            type_reg  <= s_tuser;
            row_reg   <= s_tdata[1:0];
            col_reg   <= s_tdata[5:2];
            value_reg <= s_tdata[37:6];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            frame_reg   <= {emit_is_data ? SYNC_DATA : SYNC_CMD,
                            emit_byte[7:4], 4'd0, emit_byte[3:0], 4'd0};
            payload_reg <= emit_byte;
            is_data_reg <= emit_is_data;
            settle_reg  <= emit_is_data ? data_settle_reg : cmd_settle_reg;
            last_reg    <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, settle_reg, payload_reg, frame_reg};
    assign m_tuser  = is_data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- verif/testbench.sv -----
// Self-checking stream testbench for the serial LCD number writer.
`timescale 1ns / 1ps

module testbench;
    import slnw_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int QUIET_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int NUM_DIRECTED    = 24;

    localparam logic [2:0] REQ_SPARE_5 = 3'd5;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int REG_CMD_SETTLE  = 0;
    localparam int REG_DATA_SETTLE = 1;

    localparam logic [7:0] LINE_BASE [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  line;
        logic [3:0]  col;
        logic [31:0] value;
    } lcd_req_t;

    typedef struct packed {
        logic [23:0] frame;
        logic [7:0]  payload;
        logic        is_data;
        logic [9:0]  settle;
        logic        last;
    } lcd_frame_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  line;
        logic [3:0]  col;
        logic [31:0] value;
        logic        typed;
        logic [23:0] frame;
        logic [7:0]  payload;
        logic [9:0]  settle;
    } dir_row_t;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{REQ_CMD,     2'd0, 4'd0,  32'h0000_0000, 1'b1, 24'hF80000, 8'h00, 10'd10},
        '{REQ_CMD,     2'd0, 4'd0,  32'hFFFF_FFFF, 1'b1, 24'hF8F0F0, 8'hFF, 10'd10},
        '{REQ_DATA,    2'd0, 4'd0,  32'h0000_0000, 1'b1, 24'hFA0000, 8'h00, 10'd50},
        '{REQ_DATA,    2'd0, 4'd0,  32'hFFFF_FFFF, 1'b1, 24'hFAF0F0, 8'hFF, 10'd50},
        '{REQ_DATA,    2'd3, 4'd15, 32'h0000_0041, 1'b1, 24'hFA4010, 8'h41, 10'd50},
        '{REQ_BYTE,    2'd0, 4'd0,  32'h0000_0000, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_BYTE,    2'd1, 4'd15, 32'h0000_00FF, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_BYTE,    2'd2, 4'd7,  32'h0001_2345, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_INT,     2'd0, 4'd0,  32'h0000_0000, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_INT,     2'd3, 4'd15, 32'h0000_0001, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_INT,     2'd1, 4'd2,  32'hFFFF_FFFF, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_INT,     2'd2, 4'd9,  32'h7FFF_FFFF, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_INT,     2'd0, 4'd4,  32'h8000_0000, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_INT,     2'd1, 4'd0,  32'h0098_9680, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_INT,     2'd3, 4'd1,  32'hFF67_6980, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_INT,     2'd2, 4'd3,  32'h0098_967F, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_INT,     2'd2, 4'd8,  32'h0012_D687, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_TEMP,    2'd0, 4'd0,  32'h0000_0000, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_TEMP,    2'd3, 4'd15, 32'h0000_FFFF, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_TEMP,    2'd1, 4'd3,  32'h0000_00FD, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_TEMP,    2'd2, 4'd5,  32'hFFFF_0999, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_SPARE_5, 2'd0, 4'd0,  32'h0000_0000, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_SPARE_6, 2'd3, 4'd15, 32'hFFFF_FFFF, 1'b0, 24'h0, 8'h0, 10'd0},
        '{REQ_SPARE_7, 2'd1, 4'd6,  32'h1234_5678, 1'b0, 24'h0, 8'h0, 10'd0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // row_index[1:0], column[5:2], value[37:6], zero[39:38]
    logic [2:0]  s_tuser;   // req_type[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // frame[23:0], payload[31:24], settle_us[41:32], zero[47:42]
    logic        m_tuser;   // is_data[0]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcd_frame_t frames_due[$];
    logic [9:0] cmd_settle;
    logic [9:0] data_settle;
    int         mismatches;
    int         stall_cycles;
    bit         hold_off_req;

    serial_lcd_number_writer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %h expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_frame(logic [7:0] ch, logic is_data);
        lcd_frame_t f;
        f.frame   = {is_data ? SYNC_DATA : SYNC_CMD, ch[7:4], 4'h0, ch[3:0], 4'h0};
        f.payload = ch;
        f.is_data = is_data;
        f.settle  = is_data ? data_settle : cmd_settle;
        f.last    = 1'b0;
        frames_due.push_back(f);
    endfunction

    function automatic void predict_frames(lcd_req_t r);
        int          first;
        logic [7:0]  addr;
        logic [31:0] mag;
        logic [15:0] t;
        longint      divisor;
        logic [3:0]  digit;
        bit          started;
        first   = frames_due.size();
        addr    = LINE_BASE[r.line] + 8'(r.col);
        t       = r.value[15:0];
        started = 1'b0;
        case (r.kind)
            REQ_CMD: push_frame(r.value[7:0], 1'b0);
            REQ_DATA: push_frame(r.value[7:0], 1'b1);
            REQ_BYTE: begin
                push_frame(addr, 1'b0);
                push_frame(8'(r.value[7:0] / 100) + CHR_ZERO, 1'b1);
                push_frame(8'(r.value[7:0] / 10 % 10) + CHR_ZERO, 1'b1);
                push_frame(8'(r.value[7:0] % 10) + CHR_ZERO, 1'b1);
            end
            REQ_TEMP: begin
                push_frame(addr, 1'b0);
                push_frame(8'(t / 100) + CHR_ZERO, 1'b1);
                push_frame(8'(t / 10 % 10) + CHR_ZERO, 1'b1);
                push_frame(CHR_DOT, 1'b1);
                push_frame(8'(t % 10) + CHR_ZERO, 1'b1);
                push_frame(CHR_CEL, 1'b1);
            end
            REQ_INT: begin
                push_frame(addr, 1'b0);
                repeat (BLANK_CELLS) push_frame(CHR_SPACE, 1'b1);
                push_frame(addr, 1'b0);
                if (r.value == 32'd0) begin
                    push_frame(addr, 1'b0);
                    push_frame(CHR_ZERO, 1'b1);
                    repeat (BLANK_CELLS - 1) push_frame(CHR_SPACE, 1'b1);
                end else begin
                    mag = r.value;
                    if (r.value[31]) begin
                        push_frame(CHR_MINUS, 1'b1);
                        mag = -r.value;
                    end
                    divisor = 1;
                    repeat (PRINT_DIGITS - 1) divisor = divisor * 10;
                    while (divisor > 0) begin
                        digit = 4'((longint'(mag) / divisor) % 10);
                        if (started || digit != 4'd0) begin
                            started = 1'b1;
                            push_frame(CHR_ZERO + 8'(digit), 1'b1);
                        end
                        divisor = divisor / 10;
                    end
                end
            end
            default: ;
        endcase
        if (frames_due.size() > first) frames_due[frames_due.size() - 1].last = 1'b1;
    endfunction

    function automatic lcd_req_t random_request();
        lcd_req_t r;
        int       roll;
        int       sel;
        int       magnitude;
        roll    = $urandom_range(0, 99);
        r.kind  = (roll < 8) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        r.line  = 2'($urandom_range(0, 3));
        r.col   = 4'($urandom_range(0, 15));
        r.value = $urandom();
        sel     = $urandom_range(0, 9);
        if (r.kind == REQ_TEMP && sel < 5) begin
            r.value[15:0] = 16'($urandom_range(0, 999));
        end else if (r.kind == REQ_INT && sel >= 3) begin
            if (sel < 6) magnitude = $urandom_range(0, 2000);
            else if (sel < 9) magnitude = $urandom_range(1, 214) * 10000000
                                          + $urandom_range(0, 20) - 10;
            else magnitude = 0;
            r.value = $urandom_range(0, 1) ? -magnitude : magnitude;
            if (sel == 9) begin
                case ($urandom_range(0, 3))
                    0: r.value = 32'h8000_0000;
                    1: r.value = 32'h7FFF_FFFF;
                    2: r.value = 32'hFFFF_FFFF;
                    default: r.value = 32'h0;
                endcase
            end
        end
        return r;
    endfunction

    task automatic offer_request(input lcd_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {2'b00, r.value, r.col, r.line};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_frames();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (frames_due.size() != 0);
    endtask

    task automatic write_reg(input int index, input logic [9:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * index);
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (index == REG_CMD_SETTLE) cmd_settle = value;
        else data_settle = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(value)) report_mismatch("register readback", prdata, 32'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input logic [9:0] cmd_value, input logic [9:0] data_value,
                             input int count, input bit hold_off, input int pause_at);
        lcd_req_t r;
        int       served;
        served = 0;
        drain_frames();
        repeat (QUIET_CYCLES) @(posedge aclk);
        write_reg(REG_CMD_SETTLE, cmd_value);
        write_reg(REG_DATA_SETTLE, data_value);
        hold_off_req = hold_off;
        while (served < count) begin
            r = random_request();
            offer_request(r);
            predict_frames(r);
            if (r.kind <= REQ_TEMP) served++;
            if (served == pause_at) begin
                drain_frames();
                served++;
            end
        end
    endtask

    initial begin
        lcd_req_t r;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        cmd_settle   = 10'd10;
        data_settle  = 10'd50;
        mismatches   = 0;
        hold_off_req = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            r = '{DIRECTED[i].kind, DIRECTED[i].line, DIRECTED[i].col, DIRECTED[i].value};
            offer_request(r);
            if (DIRECTED[i].typed)
                frames_due.push_back('{DIRECTED[i].frame, DIRECTED[i].payload,
                                       r.kind == REQ_DATA, DIRECTED[i].settle, 1'b1});
            else
                predict_frames(r);
        end

        run_phase(10'd0, 10'd0, 30, 1'b1, -1);
        run_phase(10'd1023, 10'd1023, 30, 1'b0, 15);
        run_phase(10'($urandom_range(1, 1022)), 10'($urandom_range(1, 1022)), 30, 1'b0, -1);
        run_phase(10'd1023, 10'd0, 30, 1'b0, -1);

        drain_frames();
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("serial_lcd_number_writer test passed");
        end else begin
            $display("serial_lcd_number_writer test failed");
        end
        $finish;
    end

    initial begin
        int run_len;
        int gap;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            run_len = $urandom_range(1, 30);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        lcd_frame_t got;
        lcd_frame_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[23:0], m_tdata[31:24], m_tuser, m_tdata[41:32], m_tlast};
            if (frames_due.size() == 0) begin
                report_mismatch("frame without expectation", 32'(got.frame), 32'h0);
            end else begin
                want = frames_due.pop_front();
                if (got.frame !== want.frame)
                    report_mismatch("frame", 32'(got.frame), 32'(want.frame));
                if (got.payload !== want.payload)
                    report_mismatch("payload", 32'(got.payload), 32'(want.payload));
                if (got.is_data !== want.is_data)
                    report_mismatch("is_data", 32'(got.is_data), 32'(want.is_data));
                if (got.settle !== want.settle)
                    report_mismatch("settle_us", 32'(got.settle), 32'(want.settle));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("serial_lcd_number_writer test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// ----- files.f -----
hw/rtl/slnw_pkg.sv
hw/rtl/slnw_bcd_conv.sv
hw/rtl/serial_lcd_number_writer.sv
verif/testbench.sv
